[design/two_digit_decimal_radix_sorter_core_defines.svh]
// Assertion macros for the port checker of the radix sorter core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TWO_DIGIT_DECIMAL_RADIX_SORTER_CORE_DEFINES_SVH
`define TWO_DIGIT_DECIMAL_RADIX_SORTER_CORE_DEFINES_SVH

// Same-cycle implication, skipped while reset is high
`define RDXS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radix sorter port assertion failed");

// Next-cycle implication, skipped while reset is high
`define RDXS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radix sorter port assertion failed");

`endif

[design/rdxs_pkg.sv]
// Shared constants and types for the two-digit decimal radix sorter core.
// No dependencies; used by the key unit, the sort cells and the top level.
`default_nettype none

package rdxs_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ITEMS   = 64;
  localparam int DEF_VALUE_WIDTH = 16;

  // Fixed port field width
  localparam int FIELD_WIDTH = 16;

  // Sort key: value modulo 100, fits in 7 bits
  localparam int KEY_WIDTH = 7;
  localparam int RADIX_SQ  = 100;

  // Arrival index kept below the key so equal keys leave in arrival order;
  // six bits cover the largest allowed set of 64 values
  localparam int SEQ_WIDTH      = 6;
  localparam int SORT_KEY_WIDTH = KEY_WIDTH + SEQ_WIDTH;

  // Reciprocal multiply for an exact unsigned divide by 100 over 32 bits
  localparam int              MUL_WIDTH   = 32;
  localparam logic [31:0]     RECIP_100   = 32'd1374389535;
  localparam int              RECIP_SHIFT = 37;

  // Register stages in the key unit
  localparam int KEY_PIPE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_UNLOAD
  } state_t;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic insert;  // pass new entries forward and keep the smaller key
    logic shift;   // move every held entry one place toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/rdxs_key.sv]
// Sort key unit: two register stages that compute value modulo 100.
// Depends on rdxs_pkg for the reciprocal constant and key width.
`default_nettype none

module rdxs_key import rdxs_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output logic                        out_valid,
  output logic [VALUE_WIDTH-1:0]      out_value,
  output logic [KEY_WIDTH-1:0]        out_key
);

  localparam int PROD_WIDTH = 2 * MUL_WIDTH;

  logic                   s1_valid;
  logic [VALUE_WIDTH-1:0] s1_value;
  logic [PROD_WIDTH-1:0]  s1_prod;
  logic [PROD_WIDTH-1:0]  prod_c;
  logic [MUL_WIDTH-1:0]   s1_wide;
  logic [MUL_WIDTH-1:0]   quot_c;
  logic [MUL_WIDTH-1:0]   rem_c;

  // Stage 1: multiply by the reciprocal of 100
  assign prod_c = PROD_WIDTH'(MUL_WIDTH'(in_value)) * PROD_WIDTH'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_value <= in_value;
    s1_prod  <= prod_c;
  end

  // Stage 2: remainder = value - quotient * 100
  assign s1_wide = MUL_WIDTH'(s1_value);
  assign quot_c  = MUL_WIDTH'(s1_prod[PROD_WIDTH-1:RECIP_SHIFT]);
  assign rem_c   = s1_wide - quot_c * MUL_WIDTH'(RADIX_SQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_value <= s1_value;
    out_key   <= rem_c[KEY_WIDTH-1:0];
  end

endmodule

`default_nettype wire

[design/rdxs_cell.sv]
// One cell of the systolic insertion chain: holds one entry, passes the larger
// key forward while loading and takes its neighbour's entry while unloading.
// Depends on rdxs_pkg for the key width and the chain control struct.
`default_nettype none

module rdxs_cell import rdxs_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cell_ctrl_t                ctrl,
  // entry arriving from the previous cell
  input  wire logic                      in_valid,
  input  wire logic [SORT_KEY_WIDTH-1:0] in_key,
  input  wire logic [VALUE_WIDTH-1:0]    in_value,
  // entry handed to the next cell
  output logic                           out_valid,
  output logic [SORT_KEY_WIDTH-1:0]      out_key,
  output logic [VALUE_WIDTH-1:0]         out_value,
  // held entry of the next cell, pulled in on a shift
  input  wire logic                      nb_valid,
  input  wire logic [SORT_KEY_WIDTH-1:0] nb_key,
  input  wire logic [VALUE_WIDTH-1:0]    nb_value,
  // entry held here
  output logic                           held_valid,
  output logic [SORT_KEY_WIDTH-1:0]      held_key,
  output logic [VALUE_WIDTH-1:0]         held_value
);

  logic take;

  // Smaller key displaces the held one; keys carry the arrival index, so none tie
  assign take = in_valid && (!held_valid || (in_key < held_key));

  // Control: occupancy and forward hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (ctrl.shift) begin
      held_valid <= nb_valid;
      out_valid  <= 1'b0;
    end else if (ctrl.insert) begin
      if (take) begin
        held_valid <= 1'b1;
        out_valid  <= held_valid;
      end else begin
        out_valid  <= in_valid;
      end
    end else begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held_key   <= nb_key;
      held_value <= nb_value;
    end else if (ctrl.insert) begin
      if (take) begin
        held_key   <= in_key;
        held_value <= in_value;
        out_key    <= held_key;
        out_value  <= held_value;
      end else begin
        out_key    <= in_key;
        out_value  <= in_value;
      end
    end
  end

endmodule

`default_nettype wire

[design/two_digit_decimal_radix_sorter_core.sv]
// Two-digit decimal radix sorter core.
// Slave stream: s_tdata[15:0] carries a value, s_tlast marks the last value
// of a set. Values are taken one per cycle while s_tready is high; once
// MAX_ITEMS are held, further values are dropped and the run is flagged.
// Master stream: the set comes out ordered by value modulo 100, ties in arrival
// order (the same order as a stable ones-then-tens bucket sort). m_tlast
// marks the last result, m_tuser is high on every result of a run in which
// values were dropped.
// Timing: values load one per cycle; after the last value the chain settles
// in a drain phase while the entries ripple through the cell chain behind
// the two-stage key unit; then one result per cycle while m_tready is high.
// s_tready is low from the last value until the last result is taken.
// Reset empties the chain and returns to loading; no clearing pass is needed.
// When the receiver stalls, the head cell holds its result and the chain
// stays put until m_tready returns.
// Depends on rdxs_pkg, rdxs_key and rdxs_cell.
`default_nettype none

module two_digit_decimal_radix_sorter_core import rdxs_pkg::*; #(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [FIELD_WIDTH-1:0] s_tdata,   // [15:0] value
  input  wire logic                   s_tlast,   // last
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [FIELD_WIDTH-1:0]      m_tdata,   // [15:0] sorted_value
  output logic                        m_tlast,   // final_res
  output logic                        m_tuser    // overflow
);

  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DRAIN_LEN = MAX_ITEMS + KEY_PIPE_DEPTH + 1;
  localparam int DRN_W     = $clog2(DRAIN_LEN + 1);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  item_count;
  logic [DRN_W-1:0]  drain_cnt;
  logic              dropped;
  cell_ctrl_t        ctrl;

  logic              in_req;
  logic              out_req;
  logic              full;
  logic              ins_valid;
  logic [VALUE_WIDTH-1:0] ins_value;

  // Key unit result and arrival index of the entry it hands on
  logic                   key_valid;
  logic [VALUE_WIDTH-1:0] key_value;
  logic [KEY_WIDTH-1:0]   key_mod;
  logic [SEQ_WIDTH-1:0]   key_seq;

  // Chain links: forward hand-off and held entries
  logic                      fv   [0:MAX_ITEMS];
  logic [SORT_KEY_WIDTH-1:0] fk   [0:MAX_ITEMS];
  logic [VALUE_WIDTH-1:0]    fval [0:MAX_ITEMS];
  logic                      hv   [0:MAX_ITEMS];
  logic [SORT_KEY_WIDTH-1:0] hk   [0:MAX_ITEMS];
  logic [VALUE_WIDTH-1:0]    hval [0:MAX_ITEMS];

  // Request handshakes
  assign in_req  = s_tvalid && s_tready;
  assign out_req = m_tvalid && m_tready;
  assign full    = (item_count == CNT_W'(MAX_ITEMS));

  // Value masked to the stored width
  assign ins_value = VALUE_WIDTH'(MUL_WIDTH'(s_tdata));
  assign ins_valid = in_req && !full;

  // Key unit feeds the head of the chain
  rdxs_key #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_key (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ins_valid),
    .in_value (ins_value),
    .out_valid(key_valid),
    .out_value(key_value),
    .out_key  (key_mod)
  );

  // Arrival index of entries leaving the key unit, cleared once the set unloads
  always_ff @(posedge clk) begin
    if (rst || (state == ST_UNLOAD)) begin
      key_seq <= '0;
    end else if (key_valid) begin
      key_seq <= key_seq + SEQ_WIDTH'(1);
    end
  end

  // Head entry: key above arrival index
  assign fv[0]   = key_valid;
  assign fval[0] = key_value;
  assign fk[0]   = {key_mod, key_seq};

  // Empty entry behind the tail
  assign hv[MAX_ITEMS]   = 1'b0;
  assign hk[MAX_ITEMS]   = '0;
  assign hval[MAX_ITEMS] = '0;

  // Row of sort cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rdxs_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .in_valid  (fv[i]),
      .in_key    (fk[i]),
      .in_value  (fval[i]),
      .out_valid (fv[i+1]),
      .out_key   (fk[i+1]),
      .out_value (fval[i+1]),
      .nb_valid  (hv[i+1]),
      .nb_key    (hk[i+1]),
      .nb_value  (hval[i+1]),
      .held_valid(hv[i]),
      .held_key  (hk[i]),
      .held_value(hval[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_req && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == DRN_W'(DRAIN_LEN - 1)) begin
          state_next = ST_UNLOAD;
        end
      end
      ST_UNLOAD: begin
        if (out_req && (item_count == CNT_W'(1))) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready    = 1'b1;
        ctrl.insert = 1'b1;
      end
      ST_DRAIN: begin
        ctrl.insert = 1'b1;
      end
      ST_UNLOAD: begin
        m_tvalid   = hv[0];
        ctrl.shift = hv[0] && m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // State, counts and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      item_count <= '0;
      drain_cnt  <= '0;
      dropped    <= 1'b0;
    end else begin
      state <= state_next;
      if (ins_valid) begin
        item_count <= item_count + CNT_W'(1);
      end else if (out_req) begin
        item_count <= item_count - CNT_W'(1);
      end
      if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + DRN_W'(1);
      end else begin
        drain_cnt <= '0;
      end
      if (in_req && full) begin
        dropped <= 1'b1;
      end else if (out_req && (item_count == CNT_W'(1))) begin
        dropped <= 1'b0;
      end
    end
  end

  // Result from the head cell
  assign m_tdata = FIELD_WIDTH'(MUL_WIDTH'(hval[0]));
  assign m_tlast = (item_count == CNT_W'(1));
  assign m_tuser = dropped;

endmodule

`default_nettype wire

[design/rdxs_checker.sv]
// Port-level checks for the radix sorter core, bound to the top level.
// Depends on the assertion macros in two_digit_decimal_radix_sorter_core_defines.svh.
`default_nettype none
`include "two_digit_decimal_radix_sorter_core_defines.svh"

module rdxs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic m_tlast,
  input wire logic m_tuser
);

  // A stalled result stays offered
  `RDXS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

  // Loading and unloading never overlap
  `RDXS_ASSERT_IMPLIES(a_no_overlap, m_tvalid, !s_tready)

  // Inside a run the next result follows at once and keeps the overflow flag
  `RDXS_ASSERT_NEXT(a_run_cont, m_tvalid && m_tready && !m_tlast,
                    m_tvalid && (m_tuser == $past(m_tuser)))

  // After the last result the block returns to loading
  `RDXS_ASSERT_NEXT(a_run_end, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready)

endmodule

bind two_digit_decimal_radix_sorter_core rdxs_checker u_rdxs_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);

`default_nettype wire
